### hdl/clipped_blending_pixel_writer_macros.svh
// Assertion helpers for the RTL file that checks its own logic.
// Each macro expects i_clk and i_rst_n to exist in the enclosing module.
`ifndef CLIPPED_BLENDING_PIXEL_WRITER_MACROS_SVH
`define CLIPPED_BLENDING_PIXEL_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBPW_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBPW_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cbpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbpw_pkg;

    // Frame geometry.
    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 256;
    localparam int STORE_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(STORE_SIZE);
    localparam int X_W           = $clog2(SCREEN_WIDTH);
    localparam int Y_W           = $clog2(SCREEN_HEIGHT);
    localparam int MAX_COL       = SCREEN_WIDTH - 1;
    localparam int MAX_ROW       = SCREEN_HEIGHT - 1;

    // Field widths.
    localparam int POS_W     = 13;
    localparam int COORD_W   = 14;
    localparam int ARGB_W    = 32;
    localparam int PIX_W     = 16;
    localparam int IDX_OUT_W = 16;
    localparam int WIN_W     = 8;
    localparam int BSEL_W    = 2;
    localparam int OP_W      = 2;

    // Stream and register port widths.
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;
    localparam logic [PIX_W-1:0] WHITE_565    = 16'hFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL = 2'd0,
        OP_BEGIN = 2'd1,
        OP_END   = 2'd2
    } t_op;

    typedef enum logic [BSEL_W-1:0] {
        BLEND_ALPHA  = 2'd0,
        BLEND_INVERT = 2'd1,
        BLEND_NONE   = 2'd2
    } t_blend;

    typedef enum logic [2:0] {
        REG_WIN_LEFT   = 3'd0,
        REG_WIN_TOP    = 3'd1,
        REG_WIN_RIGHT  = 3'd2,
        REG_WIN_BOTTOM = 3'd3,
        REG_BLEND_SEL  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_INIT_CLEAR,
        ST_RUN,
        ST_MASK_CLEAR
    } t_state;

endpackage

`default_nettype wire

### hdl/cbpw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written returns the old contents.
module cbpw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/cbpw_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Computes the new RGB565 value of an entry from its old value and the color.
module cbpw_blend (
    input  wire logic [cbpw_pkg::PIX_W-1:0]  i_old,
    input  wire logic [cbpw_pkg::ARGB_W-1:0] i_argb,
    input  wire logic [cbpw_pkg::BSEL_W-1:0] i_mode,
    output logic      [cbpw_pkg::PIX_W-1:0]  o_pixel
);

    import cbpw_pkg::*;

    function automatic logic [7:0] mix(input logic [7:0] o, input logic [7:0] n,
                                       input logic [7:0] a);
        logic [15:0] po;
        logic [15:0] pn;
        logic [8:0]  s;
        po = {8'd0, o} * {8'd0, ALPHA_OPAQUE - a};
        pn = {8'd0, n} * {8'd0, a};
        s  = {1'b0, po[15:8]} + {1'b0, pn[15:8]};
        return s[7:0];
    endfunction

    logic [7:0] old_r, old_g, old_b;
    logic [7:0] new_r, new_g, new_b;
    logic [7:0] alpha;
    logic [7:0] mix_r, mix_g, mix_b;
    logic [7:0] inv_r, inv_g, inv_b;

    // Expand by shifting, so that packing an expanded value gives it back.
    assign old_r = {i_old[15:11], 3'b000};
    assign old_g = {i_old[10:5], 2'b00};
    assign old_b = {i_old[4:0], 3'b000};
    assign alpha = i_argb[31:24];
    assign new_r = i_argb[23:16];
    assign new_g = i_argb[15:8];
    assign new_b = i_argb[7:0];

    assign mix_r = mix(old_r, new_r, alpha);
    assign mix_g = mix(old_g, new_g, alpha);
    assign mix_b = mix(old_b, new_b, alpha);

    assign inv_r = ALPHA_OPAQUE - old_r;
    assign inv_g = ALPHA_OPAQUE - old_g;
    assign inv_b = ALPHA_OPAQUE - old_b;

    always_comb begin
        case (i_mode)
            BLEND_ALPHA: begin
                if (alpha == 8'd0) begin
                    o_pixel = i_old;
                end else if (alpha == ALPHA_OPAQUE) begin
                    o_pixel = {new_r[7:3], new_g[7:2], new_b[7:3]};
                end else begin
                    o_pixel = {mix_r[7:3], mix_g[7:2], mix_b[7:3]};
                end
            end
            BLEND_INVERT: begin
                o_pixel = {inv_r[7:3], inv_g[7:2], inv_b[7:3]};
            end
            default: begin
                o_pixel = i_old;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/clipped_blending_pixel_writer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "clipped_blending_pixel_writer_macros.svh"

// Pixel write unit over a 256 x 256 RGB565 frame store. Each input word
// (tuser = op, tdata = pos_x, pos_y, argb) yields exactly one output word
// (tuser = written, tdata = pixel_index, pixel_value); when written is 0 the
// index and value are 0. A pixel write adds the window origin, is dropped
// outside the window, and otherwise blends into the store (alpha blend or
// invert, per blend_select; other selections leave it unchanged). While a
// shape is open, a coverage mask lets each entry be written once. Throughput
// is one word per clock while the output does not stall: the frame store
// and the coverage mask are read at the edge that accepts a word and written
// back as it leaves the first stage, and a write from the previous word is
// forwarded. A word passes through the first stage and the output register.
// After reset the block fills the frame store with white and clears the
// mask, with s_axis_tready low. A begin-shape word with a color that is not
// opaque clears the mask again: s_axis_tready stays low while that word
// waits in the first stage and then through the clearing pass that starts
// once it moves on to the output register. Registers should be written only
// while the block is idle, since a write takes effect at once and would
// change how words already in flight are handled.
module clipped_blending_pixel_writer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input stream.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata bits from 0: pos_x[12:0], pos_y[25:13], argb[57:26], zero pad.
    input  wire logic [cbpw_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser bits from 0: op[1:0].
    input  wire logic [cbpw_pkg::OP_W-1:0]         s_axis_tuser,
    // Output stream.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata bits from 0: pixel_index[15:0], pixel_value[31:16].
    output logic      [cbpw_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser bits from 0: written[0].
    output logic      [0:0]                        m_axis_tuser,
    // Register port.
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cbpw_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [cbpw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [cbpw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    import cbpw_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]  r_win_left;
    logic [WIN_W-1:0]  r_win_top;
    logic [WIN_W-1:0]  r_win_right;
    logic [WIN_W-1:0]  r_win_bottom;
    logic [BSEL_W-1:0] r_blend_sel;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_top    <= '0;
            r_win_right  <= '1;
            r_win_bottom <= '1;
            r_blend_sel  <= BLEND_ALPHA;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WIN_LEFT:   r_win_left   <= pwdata[WIN_W-1:0];
                REG_WIN_TOP:    r_win_top    <= pwdata[WIN_W-1:0];
                REG_WIN_RIGHT:  r_win_right  <= pwdata[WIN_W-1:0];
                REG_WIN_BOTTOM: r_win_bottom <= pwdata[WIN_W-1:0];
                REG_BLEND_SEL:  r_blend_sel  <= pwdata[BSEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIN_LEFT:   prdata = APB_DATA_W'(r_win_left);
            REG_WIN_TOP:    prdata = APB_DATA_W'(r_win_top);
            REG_WIN_RIGHT:  prdata = APB_DATA_W'(r_win_right);
            REG_WIN_BOTTOM: prdata = APB_DATA_W'(r_win_bottom);
            REG_BLEND_SEL:  prdata = APB_DATA_W'(r_blend_sel);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input stage: offset, clip and address computation. The memory reads
    // for the word are issued at the edge that accepts it.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   in_pos_x;
    logic [POS_W-1:0]   in_pos_y;
    logic [ARGB_W-1:0]  in_argb;
    logic [COORD_W-1:0] x_sum;
    logic [COORD_W-1:0] y_sum;
    logic [COORD_W-1:0] right_eff;
    logic [COORD_W-1:0] bottom_eff;
    logic               in_visible;
    logic [ADDR_W-1:0]  in_idx;
    logic               in_acc;

    assign in_pos_x = s_axis_tdata[12:0];
    assign in_pos_y = s_axis_tdata[25:13];
    assign in_argb  = s_axis_tdata[57:26];

    // Negative relative positions are rejected below, so only the magnitude
    // bits enter the sums.
    assign x_sum = COORD_W'(in_pos_x[POS_W-2:0]) + COORD_W'(r_win_left);
    assign y_sum = COORD_W'(in_pos_y[POS_W-2:0]) + COORD_W'(r_win_top);

    // The window edges are limited to the screen.
    assign right_eff  = (COORD_W'(r_win_right) > COORD_W'(MAX_COL)) ?
                        COORD_W'(MAX_COL) : COORD_W'(r_win_right);
    assign bottom_eff = (COORD_W'(r_win_bottom) > COORD_W'(MAX_ROW)) ?
                        COORD_W'(MAX_ROW) : COORD_W'(r_win_bottom);

    assign in_visible = (s_axis_tuser == OP_PIXEL) &&
                        !in_pos_x[POS_W-1] && !in_pos_y[POS_W-1] &&
                        (x_sum <= right_eff) && (y_sum <= bottom_eff);

    assign in_idx = ADDR_W'(y_sum[Y_W-1:0]) * ADDR_W'(SCREEN_WIDTH) +
                    ADDR_W'(x_sum[X_W-1:0]);

    // ------------------------------------------------------------------
    // Control state: clearing passes and the shape flag.
    // ------------------------------------------------------------------
    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic [ADDR_W-1:0] n_clr_cnt;
    logic              r_shape_open;

    // Stage one registers.
    logic              r_s1_valid;
    logic              r_s1_vis;
    logic              r_s1_begin_clr;
    logic              r_s1_end;
    logic [ADDR_W-1:0] r_s1_idx;
    logic [ARGB_W-1:0] r_s1_argb;

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_written;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [PIX_W-1:0]     r_out_value;

    logic out_free;
    logic s1_adv;

    assign out_free = !r_out_valid || m_axis_tready;
    assign s1_adv   = r_s1_valid && out_free;

    // A begin shape that clears the mask must drain before anything follows,
    // so that no later pixel reads the mask ahead of the clearing pass.
    assign s_axis_tready = (r_state == ST_RUN) &&
                           !(r_s1_valid && (r_s1_begin_clr || !out_free));
    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        case (r_state)
            ST_INIT_CLEAR, ST_MASK_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == ADDR_W'(STORE_SIZE - 1)) begin
                    n_state   = ST_RUN;
                    n_clr_cnt = '0;
                end
            end
            ST_RUN: begin
                if (s1_adv && r_s1_begin_clr) begin
                    n_state = ST_MASK_CLEAR;
                end
            end
            default: begin
                n_state   = ST_INIT_CLEAR;
                n_clr_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_open <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1_begin_clr) begin
                r_shape_open <= 1'b1;
            end else if (r_s1_end) begin
                r_shape_open <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_vis       <= in_visible;
            r_s1_begin_clr <= (s_axis_tuser == OP_BEGIN) &&
                              (in_argb[31:24] != ALPHA_OPAQUE);
            r_s1_end       <= (s_axis_tuser == OP_END);
            r_s1_idx       <= in_idx;
            r_s1_argb      <= in_argb;
        end
    end

    // ------------------------------------------------------------------
    // Memories with forwarding of the most recent write.
    // ------------------------------------------------------------------
    logic              clr_store;
    logic              clr_mask;
    logic [PIX_W-1:0]  st_rdata;
    logic              mk_rdata;
    logic [PIX_W-1:0]  st_old;
    logic              mk_old;
    logic              masked;
    logic              hit;
    logic              st_item_wr;
    logic              st_wr;
    logic              mk_wr;
    logic [PIX_W-1:0]  new_pixel;

    logic              r_fwd_st_valid;
    logic [ADDR_W-1:0] r_fwd_st_addr;
    logic [PIX_W-1:0]  r_fwd_st_data;
    logic              r_fwd_mk_valid;
    logic [ADDR_W-1:0] r_fwd_mk_addr;

    assign clr_store = (r_state == ST_INIT_CLEAR);
    assign clr_mask  = (r_state == ST_INIT_CLEAR) || (r_state == ST_MASK_CLEAR);

    // The read data of a word held in stage one stays put while the output
    // stalls, since reads are only enabled on acceptance. A write made at
    // the accepting edge is not yet in the read data, hence the forwarding.
    assign st_old = (r_fwd_st_valid && (r_fwd_st_addr == r_s1_idx)) ?
                    r_fwd_st_data : st_rdata;
    assign mk_old = (r_fwd_mk_valid && (r_fwd_mk_addr == r_s1_idx)) ? 1'b1 : mk_rdata;

    assign masked     = r_shape_open && mk_old;
    assign hit        = r_s1_valid && r_s1_vis && !masked;
    assign st_item_wr = hit && ((r_blend_sel == BLEND_ALPHA) ||
                                (r_blend_sel == BLEND_INVERT));
    assign st_wr      = s1_adv && st_item_wr;
    // The mask bit is set even when the store is left unchanged.
    assign mk_wr      = s1_adv && hit && r_shape_open;

    cbpw_blend u_blend (
        .i_old   (st_old),
        .i_argb  (r_s1_argb),
        .i_mode  (r_blend_sel),
        .o_pixel (new_pixel)
    );

    cbpw_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_SIZE)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (clr_store || st_wr),
        .i_waddr (clr_store ? r_clr_cnt : r_s1_idx),
        .i_wdata (clr_store ? WHITE_565 : new_pixel),
        .i_re    (in_acc),
        .i_raddr (in_idx),
        .o_rdata (st_rdata)
    );

    cbpw_ram #(
        .WIDTH (1),
        .DEPTH (STORE_SIZE)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (clr_mask || mk_wr),
        .i_waddr (clr_mask ? r_clr_cnt : r_s1_idx),
        .i_wdata (!clr_mask),
        .i_re    (in_acc),
        .i_raddr (in_idx),
        .o_rdata (mk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_st_valid <= 1'b0;
        end else if (clr_store) begin
            r_fwd_st_valid <= 1'b0;
        end else if (st_wr) begin
            r_fwd_st_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_wr) begin
            r_fwd_st_addr <= r_s1_idx;
            r_fwd_st_data <= new_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_mk_valid <= 1'b0;
        end else if (clr_mask) begin
            r_fwd_mk_valid <= 1'b0;
        end else if (mk_wr) begin
            r_fwd_mk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mk_wr) begin
            r_fwd_mk_addr <= r_s1_idx;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_written <= st_item_wr;
            r_out_idx     <= st_item_wr ? IDX_OUT_W'(r_s1_idx) : '0;
            r_out_value   <= st_item_wr ? new_pixel : '0;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tuser[0] = r_out_written;
    assign m_axis_tdata    = {r_out_value, r_out_idx};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CBPW_ASSERT(a_accept_only_in_run, s_axis_tvalid && s_axis_tready, r_state == ST_RUN, "word accepted during a clearing pass")
    `CBPW_ASSERT(a_no_item_write_while_clearing, r_state != ST_RUN, !st_wr && !mk_wr, "item write during a clearing pass")
    `CBPW_ASSERT_NEXT(a_forward_tracks_write, st_wr, r_fwd_st_valid && (r_fwd_st_addr == $past(r_s1_idx)), "forward register missed a store write")
    `CBPW_ASSERT(a_mask_clear_opens_shape, r_state == ST_MASK_CLEAR, r_shape_open, "mask clear without an open shape")

endmodule

`default_nettype wire
